[design/loop_scan_match_pose_resolve_macros.svh]
// ----------------------------------------------------------------------------
// Loop scan match pose resolve: assertion macros
// Shared macros for concurrent checks clocked on i_clk under i_rst_n.
// ----------------------------------------------------------------------------
`ifndef LOOP_SCAN_MATCH_POSE_RESOLVE_MACROS_SVH
`define LOOP_SCAN_MATCH_POSE_RESOLVE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSMPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lsmpr check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSMPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lsmpr check failed");

`endif

[design/lsmpr_pkg.sv]
// ----------------------------------------------------------------------------
// Loop scan match pose resolve: shared package
// Widths, codes, record layout, sine table and saturation helpers.
// ----------------------------------------------------------------------------
package lsmpr_pkg;

    localparam int MAX_SCANS = 256;
    localparam int CNT_W     = $clog2(MAX_SCANS + 1);
    localparam int ADDR_W    = $clog2(MAX_SCANS);
    localparam int STAMP_W   = 63;
    localparam int ID_W      = 32;
    localparam int POS_W     = 32;
    localparam int ANG_W     = 16;
    localparam int SIN_W     = 16;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 36;

    localparam logic [STAMP_W-1:0] GAP_RESET = STAMP_W'(50000000);

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_RESOLVE = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_RESOLVED  = 4'd0,
        ST_INVALID   = 4'd1,
        ST_QUERY_NONE = 4'd2,
        ST_CAND_NONE = 4'd3,
        ST_SAME      = 4'd4,
        ST_ORDER     = 4'd5,
        ST_LOADED    = 4'd6,
        ST_FULL      = 4'd7,
        ST_CLEARED   = 4'd8
    } t_status;

    typedef struct packed {
        logic [STAMP_W-1:0]      stamp;
        logic [ID_W-1:0]         ident;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic [ANG_W-1:0]        heading;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               done;
        logic [STAMP_W-1:0] q_dist;
        logic [ID_W-1:0]    q_ident;
        logic [STAMP_W-1:0] q_stamp;
        logic [STAMP_W-1:0] c_dist;
        t_entry             c_entry;
    } t_match_res;

    typedef struct packed {
        logic                    done;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [ANG_W-1:0]        yaw;
    } t_pose_res;

    typedef logic [256:0][SIN_W-1:0] t_qtab;

    function automatic logic [SIN_W-1:0] sine_quarter(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          r;
        x    = (longint'(k) * 64'd3373259426 + 64'd256) >> 9;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum * 32768 + (longint'(1) << 29)) >>> 30;
        if (r > 32767) begin
            r = 32767;
        end
        return SIN_W'(r);
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab t;
        for (int k = 0; k <= 256; k++) begin
            t[k] = sine_quarter(k);
        end
        return t;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    function automatic logic signed [SIN_W-1:0] sine_at(input logic [9:0] k);
        logic [8:0]              m;
        logic [8:0]              j;
        logic signed [SIN_W-1:0] q;
        m = k[8:0];
        j = (m <= 9'd256) ? m : 9'(10'd512 - {1'b0, m});
        q = $signed(QTAB[j]);
        return k[9] ? -q : q;
    endfunction

    function automatic logic signed [SIN_W-1:0] sin_of(input logic [ANG_W-1:0] a);
        return sine_at(a[15:6]);
    endfunction

    function automatic logic signed [SIN_W-1:0] cos_of(input logic [ANG_W-1:0] a);
        return sine_at(a[15:6] + 10'd256);
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > $signed({{(ACC_W-POS_W){1'b0}}, 1'b0, {(POS_W-1){1'b1}}})) begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
        if (v < $signed({{(ACC_W-POS_W){1'b1}}, 1'b1, {(POS_W-1){1'b0}}})) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end
        return v[POS_W-1:0];
    endfunction

endpackage

[design/lsmpr_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lsmpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/lsmpr_match.sv]
// ----------------------------------------------------------------------------
// Nearest scan tracker
// Walks the stored records once and keeps the nearest match for both stamps.
// ----------------------------------------------------------------------------
module lsmpr_match (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lsmpr_pkg::CNT_W-1:0]   i_count,
    input  logic [lsmpr_pkg::STAMP_W-1:0] i_stamp_q,
    input  logic [lsmpr_pkg::STAMP_W-1:0] i_stamp_c,
    output logic                          o_rd_en,
    output logic [lsmpr_pkg::ADDR_W-1:0]  o_rd_addr,
    input  lsmpr_pkg::t_entry             i_rd_data,
    output lsmpr_pkg::t_match_res         o_res
);
    import lsmpr_pkg::*;

    logic               r_issuing;
    logic [CNT_W-1:0]   r_idx;
    logic               r_rv;
    logic               r_rv_last;
    logic               r_s1_v;
    logic               r_s1_last;
    logic [STAMP_W-1:0] r_s1_dq;
    logic [STAMP_W-1:0] r_s1_dc;
    t_entry             r_s1_e;
    logic               r_done;
    logic               r_have;
    logic [STAMP_W-1:0] r_bq_d;
    logic [ID_W-1:0]    r_bq_id;
    logic [STAMP_W-1:0] r_bq_stamp;
    logic [STAMP_W-1:0] r_bc_d;
    t_entry             r_bc_e;
    logic               w_last;
    logic [STAMP_W-1:0] w_dq;
    logic [STAMP_W-1:0] w_dc;
    logic               w_take_q;
    logic               w_take_c;

    assign w_last    = (r_idx == i_count - CNT_W'(1));
    assign o_rd_en   = r_issuing;
    assign o_rd_addr = r_idx[ADDR_W-1:0];

    assign w_dq = (i_rd_data.stamp >= i_stamp_q) ? i_rd_data.stamp - i_stamp_q
                                                 : i_stamp_q - i_rd_data.stamp;
    assign w_dc = (i_rd_data.stamp >= i_stamp_c) ? i_rd_data.stamp - i_stamp_c
                                                 : i_stamp_c - i_rd_data.stamp;

    assign w_take_q = !r_have || (r_s1_dq < r_bq_d)
                      || ((r_s1_dq == r_bq_d) && (r_s1_e.ident < r_bq_id));
    assign w_take_c = !r_have || (r_s1_dc < r_bc_d)
                      || ((r_s1_dc == r_bc_d) && (r_s1_e.ident < r_bc_e.ident));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_idx     <= '0;
            r_rv      <= 1'b0;
            r_rv_last <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s1_last <= 1'b0;
            r_done    <= 1'b0;
            r_have    <= 1'b0;
        end else begin
            r_rv      <= r_issuing;
            r_rv_last <= r_issuing && w_last;
            r_s1_v    <= r_rv;
            r_s1_last <= r_rv_last;
            r_done    <= r_s1_v && r_s1_last;
            if (i_start) begin
                r_issuing <= 1'b1;
                r_idx     <= '0;
                r_have    <= 1'b0;
            end else begin
                if (r_issuing) begin
                    if (w_last) begin
                        r_issuing <= 1'b0;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                if (r_s1_v) begin
                    r_have <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dq <= w_dq;
        r_s1_dc <= w_dc;
        r_s1_e  <= i_rd_data;
        if (r_s1_v && w_take_q) begin
            r_bq_d     <= r_s1_dq;
            r_bq_id    <= r_s1_e.ident;
            r_bq_stamp <= r_s1_e.stamp;
        end
        if (r_s1_v && w_take_c) begin
            r_bc_d <= r_s1_dc;
            r_bc_e <= r_s1_e;
        end
    end

    assign o_res.done    = r_done;
    assign o_res.q_dist  = r_bq_d;
    assign o_res.q_ident = r_bq_id;
    assign o_res.q_stamp = r_bq_stamp;
    assign o_res.c_dist  = r_bc_d;
    assign o_res.c_entry = r_bc_e;

endmodule

[design/lsmpr_pose.sv]
// ----------------------------------------------------------------------------
// Pose composer
// Inverts the relative pose and composes it with the candidate pose through
// one shared multiplier.
// ----------------------------------------------------------------------------
module lsmpr_pose (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [lsmpr_pkg::POS_W-1:0] i_rel_x,
    input  logic signed [lsmpr_pkg::POS_W-1:0] i_rel_y,
    input  logic [lsmpr_pkg::ANG_W-1:0]        i_rel_yaw,
    input  lsmpr_pkg::t_entry                  i_cand,
    output lsmpr_pkg::t_pose_res               o_res
);
    import lsmpr_pkg::*;

    logic                     r_busy;
    logic [3:0]               r_c;
    logic signed [SIN_W-1:0]  r_cr;
    logic signed [SIN_W-1:0]  r_sr;
    logic signed [SIN_W-1:0]  r_cc;
    logic signed [SIN_W-1:0]  r_sc;
    logic [ANG_W-1:0]         r_yaw;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc_x;
    logic signed [ACC_W-1:0]  r_acc_y;
    logic signed [POS_W-1:0]  r_ix;
    logic signed [POS_W-1:0]  r_iy;
    logic signed [SIN_W-1:0]  w_ma;
    logic signed [POS_W-1:0]  w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_fp;
    logic signed [ACC_W-1:0]  w_cx;
    logic signed [ACC_W-1:0]  w_cy;

    always_comb begin
        case (r_c)
            4'd0:    begin w_ma = r_cr; w_mb = i_rel_x; end
            4'd1:    begin w_ma = r_sr; w_mb = i_rel_y; end
            4'd2:    begin w_ma = r_sr; w_mb = i_rel_x; end
            4'd3:    begin w_ma = r_cr; w_mb = i_rel_y; end
            4'd4:    begin w_ma = r_cc; w_mb = r_ix; end
            4'd5:    begin w_ma = r_sc; w_mb = r_ix; end
            4'd6:    begin w_ma = r_sc; w_mb = r_iy; end
            default: begin w_ma = r_cc; w_mb = r_iy; end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_fp   = {{(ACC_W-PROD_W+15){r_prod[PROD_W-1]}}, r_prod[PROD_W-1:15]};
    assign w_cx   = {{(ACC_W-POS_W){i_cand.px[POS_W-1]}}, i_cand.px};
    assign w_cy   = {{(ACC_W-POS_W){i_cand.py[POS_W-1]}}, i_cand.py};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_c    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_c    <= '0;
        end else if (r_busy) begin
            if (r_c == 4'd9) begin
                r_busy <= 1'b0;
            end else begin
                r_c <= r_c + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cr  <= cos_of(i_rel_yaw);
            r_sr  <= sin_of(i_rel_yaw);
            r_cc  <= cos_of(i_cand.heading);
            r_sc  <= sin_of(i_cand.heading);
            r_yaw <= i_cand.heading - i_rel_yaw;
        end
        r_prod <= w_prod;
        if (r_busy) begin
            case (r_c)
                4'd1: r_acc_x <= -w_fp;
                4'd2: r_acc_x <= r_acc_x - w_fp;
                4'd3: begin
                    r_acc_y <= w_fp;
                    r_ix    <= sat32(r_acc_x);
                end
                4'd4: r_acc_y <= r_acc_y - w_fp;
                4'd5: begin
                    r_acc_x <= w_cx + w_fp;
                    r_iy    <= sat32(r_acc_y);
                end
                4'd6: r_acc_y <= w_cy + w_fp;
                4'd7: r_acc_x <= r_acc_x - w_fp;
                4'd8: r_acc_y <= r_acc_y + w_fp;
                default: ;
            endcase
        end
    end

    assign o_res.done = r_busy && (r_c == 4'd9);
    assign o_res.x    = sat32(r_acc_x);
    assign o_res.y    = sat32(r_acc_y);
    assign o_res.yaw  = r_yaw;

endmodule

[design/loop_scan_match_pose_resolve.sv]
// A clear, load or rejected item goes from acceptance to the done state, then to the output
// register once that is free. A resolve first walks the stored scans and checks the
// matches, and runs the pose math only when the match check passes.
// The scan walk reads the record memory once per cycle; pose math uses one multiplier.
// Throughput: one item at a time; the next item is taken once the result is queued.
// Reset: synchronous, active low; empties the table and sets max_stamp_gap to 50000000.
// ----------------------------------------------------------------------------
// Loop scan match pose resolve
// Scan record table with nearest-stamp matching and pose resolution.
// ----------------------------------------------------------------------------
module loop_scan_match_pose_resolve (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lsmpr_pkg::STAMP_W-1:0]      i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_cmd,
    input  logic [lsmpr_pkg::STAMP_W-1:0]      i_stamp_a,
    input  logic [lsmpr_pkg::STAMP_W-1:0]      i_stamp_b,
    input  logic [lsmpr_pkg::ID_W-1:0]         i_scan_id,
    input  logic signed [lsmpr_pkg::POS_W-1:0] i_pose_x,
    input  logic signed [lsmpr_pkg::POS_W-1:0] i_pose_y,
    input  logic [lsmpr_pkg::ANG_W-1:0]        i_pose_yaw,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [3:0]                         o_status,
    output logic [lsmpr_pkg::ID_W-1:0]         o_query_id,
    output logic [lsmpr_pkg::ID_W-1:0]         o_candidate_id,
    output logic signed [lsmpr_pkg::POS_W-1:0] o_out_x,
    output logic signed [lsmpr_pkg::POS_W-1:0] o_out_y,
    output logic [lsmpr_pkg::ANG_W-1:0]        o_out_yaw
);
    import lsmpr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_CHECK = 5'b00100,
        S_POSE  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                  r_state;
    logic [STAMP_W-1:0]      r_gap;
    logic [CNT_W-1:0]        r_count;
    logic [STAMP_W-1:0]      r_sa;
    logic [STAMP_W-1:0]      r_sb;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic [ANG_W-1:0]        r_yaw;
    logic                    r_match_start;
    logic                    r_pose_start;
    t_status                 r_status;
    logic [ID_W-1:0]         r_qid;
    logic [ID_W-1:0]         r_cid;
    logic signed [POS_W-1:0] r_ox;
    logic signed [POS_W-1:0] r_oy;
    logic [ANG_W-1:0]        r_oyaw;
    logic                    r_o_valid;
    t_status                 r_o_status;
    logic [ID_W-1:0]         r_o_qid;
    logic [ID_W-1:0]         r_o_cid;
    logic signed [POS_W-1:0] r_o_x;
    logic signed [POS_W-1:0] r_o_y;
    logic [ANG_W-1:0]        r_o_yaw;

    logic                    w_accept;
    logic                    w_we;
    t_entry                  w_wentry;
    logic                    w_rd_en;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic [ENTRY_W-1:0]      w_rd_bits;
    t_match_res              w_match;
    t_pose_res               w_pose;
    logic                    w_bad;
    logic                    w_push;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_we       = w_accept && (t_cmd'(i_cmd) == CMD_LOAD)
                        && (r_count < CNT_W'(MAX_SCANS));
    assign w_bad      = (r_gap == '0) || (i_stamp_a == '0) || (i_stamp_b == '0)
                        || (i_stamp_b >= i_stamp_a);
    assign w_push     = (r_state == S_DONE) && (!r_o_valid || i_out_ready);

    assign w_wentry.stamp   = i_stamp_a;
    assign w_wentry.ident   = i_scan_id;
    assign w_wentry.px      = i_pose_x;
    assign w_wentry.py      = i_pose_y;
    assign w_wentry.heading = i_pose_yaw;

    lsmpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SCANS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_bits)
    );

    lsmpr_match u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_match_start),
        .i_count   (r_count),
        .i_stamp_q (r_sa),
        .i_stamp_c (r_sb),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (t_entry'(w_rd_bits)),
        .o_res     (w_match)
    );

    lsmpr_pose u_pose (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_pose_start),
        .i_rel_x   (r_px),
        .i_rel_y   (r_py),
        .i_rel_yaw (r_yaw),
        .i_cand    (w_match.c_entry),
        .o_res     (w_pose)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_gap         <= GAP_RESET;
            r_count       <= '0;
            r_match_start <= 1'b0;
            r_pose_start  <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_match_start <= 1'b0;
            r_pose_start  <= 1'b0;
            if (i_cfg_we) begin
                r_gap <= i_cfg_wdata;
            end
            if (w_push) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DONE;
                        if (t_cmd'(i_cmd) == CMD_CLEAR) begin
                            r_count <= '0;
                        end else if (w_we) begin
                            r_count <= r_count + CNT_W'(1);
                        end else if ((t_cmd'(i_cmd) == CMD_RESOLVE) && !w_bad
                                     && (r_count != '0)) begin
                            r_state       <= S_SCAN;
                            r_match_start <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_match.done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if ((w_match.q_dist > r_gap) || (w_match.c_dist > r_gap)
                        || (w_match.q_ident == w_match.c_entry.ident)
                        || (w_match.c_entry.stamp >= w_match.q_stamp)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state      <= S_POSE;
                        r_pose_start <= 1'b1;
                    end
                end
                S_POSE: begin
                    if (w_pose.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sa   <= i_stamp_a;
            r_sb   <= i_stamp_b;
            r_px   <= i_pose_x;
            r_py   <= i_pose_y;
            r_yaw  <= i_pose_yaw;
            r_qid  <= '0;
            r_cid  <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_oyaw <= '0;
            case (t_cmd'(i_cmd))
                CMD_CLEAR: r_status <= ST_CLEARED;
                CMD_LOAD:  r_status <= w_we ? ST_LOADED : ST_FULL;
                CMD_RESOLVE: begin
                    if (w_bad) begin
                        r_status <= ST_INVALID;
                    end else begin
                        r_status <= ST_QUERY_NONE;
                    end
                end
                default: r_status <= ST_INVALID;
            endcase
        end
        if (r_state == S_CHECK) begin
            if (w_match.q_dist > r_gap) begin
                r_status <= ST_QUERY_NONE;
            end else if (w_match.c_dist > r_gap) begin
                r_status <= ST_CAND_NONE;
            end else if (w_match.q_ident == w_match.c_entry.ident) begin
                r_status <= ST_SAME;
            end else if (w_match.c_entry.stamp >= w_match.q_stamp) begin
                r_status <= ST_ORDER;
            end else begin
                r_status <= ST_RESOLVED;
            end
        end
        if ((r_state == S_POSE) && w_pose.done) begin
            r_qid  <= w_match.q_ident;
            r_cid  <= w_match.c_entry.ident;
            r_ox   <= w_pose.x;
            r_oy   <= w_pose.y;
            r_oyaw <= w_pose.yaw;
        end
        if (w_push) begin
            r_o_status <= r_status;
            r_o_qid    <= r_qid;
            r_o_cid    <= r_cid;
            r_o_x      <= r_ox;
            r_o_y      <= r_oy;
            r_o_yaw    <= r_oyaw;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_query_id     = r_o_qid;
    assign o_candidate_id = r_o_cid;
    assign o_out_x        = r_o_x;
    assign o_out_y        = r_o_y;
    assign o_out_yaw      = r_o_yaw;

endmodule

[design/lsmpr_checker.sv]
// ----------------------------------------------------------------------------
// Loop scan match pose resolve: port checker
// Watches the top-level ports and flags results that break the block rules.
// ----------------------------------------------------------------------------
`include "loop_scan_match_pose_resolve_macros.svh"

module lsmpr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic [3:0]                         o_status,
    input logic [lsmpr_pkg::ID_W-1:0]         o_query_id,
    input logic [lsmpr_pkg::ID_W-1:0]         o_candidate_id,
    input logic signed [lsmpr_pkg::POS_W-1:0] o_out_x,
    input logic signed [lsmpr_pkg::POS_W-1:0] o_out_y,
    input logic [lsmpr_pkg::ANG_W-1:0]        o_out_yaw
);
    import lsmpr_pkg::*;

    `LSMPR_ASSERT_NOW(a_status_range, o_out_valid, o_status <= 4'(ST_CLEARED))
    `LSMPR_ASSERT_NOW(a_zero_unless_resolved, o_out_valid && (o_status != 4'(ST_RESOLVED)), (o_query_id == '0) && (o_candidate_id == '0) && (o_out_x == '0) && (o_out_y == '0) && (o_out_yaw == '0))
    `LSMPR_ASSERT_NOW(a_resolved_ids_differ, o_out_valid && (o_status == 4'(ST_RESOLVED)), o_query_id != o_candidate_id)
    `LSMPR_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind loop_scan_match_pose_resolve lsmpr_checker u_lsmpr_checker (.*);
